[rtl/core/adsr_envelope_generator_assert.svh]
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop in the same cycle as cond.
`define ADSR_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("adsr check failed in same cycle");
// Check prop in the cycle after cond.
`define ADSR_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("adsr check failed in next cycle");
`else
`define ADSR_ASSERT_SAME(label, clk, rst, cond, prop)
`define ADSR_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[rtl/core/adsr_pkg.sv]
// Types and constants of the ADSR envelope generator.
package adsr_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int FRACTION_BITS  = 16;
   localparam int LEVEL_INT_BITS = 8;
   localparam int LEVEL_BITS     = LEVEL_INT_BITS + FRACTION_BITS;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

   localparam int SUM_BITS       = SAMPLE_BITS + 1;
   localparam int THRESHOLD_BITS = 13;
   localparam int GATE_CMP_BITS  = (SUM_BITS > THRESHOLD_BITS) ? SUM_BITS : THRESHOLD_BITS;

   localparam int TIME_BITS      = 8;
   localparam int SCALE_BITS     = 32;
   localparam int DIV_COUNT_BITS = $clog2(SCALE_BITS);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [7:0]  RESET_ATTACK_LEVEL   = 8'd255;
   localparam logic [7:0]  RESET_SUSTAIN_LEVEL  = 8'd128;
   localparam logic [7:0]  RESET_RELEASE_FLOOR  = 8'd0;
   localparam logic [7:0]  RESET_STAGE_TIME     = 8'd64;
   localparam logic [12:0] RESET_GATE_THRESHOLD = 13'd1365;
   localparam logic [31:0] RESET_TICK_SCALE     = 32'd1420493;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ATTACK_LEVEL   = 3'd0,
      CSR_SUSTAIN_LEVEL  = 3'd1,
      CSR_RELEASE_FLOOR  = 3'd2,
      CSR_ATTACK_TIME    = 3'd3,
      CSR_DECAY_TIME     = 3'd4,
      CSR_RELEASE_TIME   = 3'd5,
      CSR_GATE_THRESHOLD = 3'd6,
      CSR_TICK_SCALE     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_DIVIDE,
      CS_APPLY
   } ctrl_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/core/adsr_req_if.sv]
// Request channel: one word of gate samples per timer tick.
interface adsr_req_if;
   logic                              valid;
   logic                              ready;
   logic [adsr_pkg::SAMPLE_BITS-1:0]  pot_value;
   logic [adsr_pkg::SAMPLE_BITS-1:0]  jack_value;

   modport source (output valid, output pot_value, output jack_value, input ready);
   modport sink   (input valid, input pot_value, input jack_value, output ready);
endinterface

[rtl/core/adsr_rsp_if.sv]
// Response channel: one word of envelope level and stage per tick.
interface adsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] envelope;
   logic [1:0] stage;

   modport source (output valid, output envelope, output stage, input ready);
   modport sink   (input valid, input envelope, input stage, output ready);
endinterface

[rtl/core/adsr_div.sv]
// Bit-serial restoring divider: tick scale over stage time, one quotient bit per cycle.
`include "adsr_envelope_generator_assert.svh"
module adsr_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [adsr_pkg::SCALE_BITS-1:0]  dividend,
   input  logic [adsr_pkg::TIME_BITS-1:0]   divisor,
   output adsr_pkg::div_status_type         status,
   output logic [adsr_pkg::SCALE_BITS-1:0]  quotient
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [adsr_pkg::DIV_COUNT_BITS-1:0]  count_ff, count_in;
   logic [adsr_pkg::SCALE_BITS-1:0]      quo_ff, quo_in;
   logic [adsr_pkg::TIME_BITS-1:0]       rem_ff, rem_in;
   logic [adsr_pkg::TIME_BITS-1:0]       dvs_ff, dvs_in;

   logic [adsr_pkg::TIME_BITS:0]         trial;
   logic [adsr_pkg::TIME_BITS:0]         diff;
   logic                                 fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[adsr_pkg::SCALE_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (busy_ff) begin
         quo_in   = {quo_ff[adsr_pkg::SCALE_BITS-2:0], fits};
         rem_in   = fits ? diff[adsr_pkg::TIME_BITS-1:0] : trial[adsr_pkg::TIME_BITS-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         count_in = adsr_pkg::DIV_COUNT_BITS'(adsr_pkg::SCALE_BITS - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   `ADSR_ASSERT_NEXT(a_div_start, clock, reset, start && !busy_ff,
      busy_ff && count_ff == adsr_pkg::DIV_COUNT_BITS'(adsr_pkg::SCALE_BITS - 1))
   `ADSR_ASSERT_NEXT(a_div_finish, clock, reset, busy_ff && count_ff == '0,
      !busy_ff && done_ff)

endmodule

[rtl/core/adsr_envelope_generator.sv]
// Top level of the ADSR envelope generator: gate detect, stage control, level update.
//
// Each request word carries one timer tick's pot and jack samples; their sum above
// gate_threshold means gate on. A rising gate starts ATTACK from RELEASE, a low gate
// forces RELEASE. The level is an unsigned accumulator with 8 integer and
// FRACTION_BITS fraction bits; each tick in ATTACK, DECAY or RELEASE moves it by
// tick_scale / stage_time (truncated, saturated to the level range; a time of zero
// gives the full-range step), and a SUSTAIN tick sets it to the sustain level. Every
// request word yields exactly one response word holding the integer level and the
// stage after that tick. A tick in ATTACK, DECAY or RELEASE with a nonzero stage
// time runs the bit-serial divider, one bit per cycle, to form the step; the
// control then sees the divider finish, and the update step applies the step and
// loads the response register. A SUSTAIN tick or a zero stage time skips the divider
// and goes straight from acceptance to the update step. The next request is taken
// once the response register is loaded; a stalled receiver holds the finished tick
// in the update step. One tick is worked on at a time; the response register lets
// the next request be taken while the previous response waits. Write configuration
// only while no tick is in flight or waiting.
`include "adsr_envelope_generator_assert.svh"
module adsr_envelope_generator (
   input  logic                                clock,
   input  logic                                reset,
   adsr_req_if.sink                            req_ch,
   adsr_rsp_if.source                          rsp_ch,
   input  logic                                csr_wen,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers
   logic [7:0]                              attack_level_ff;
   logic [7:0]                              sustain_level_ff;
   logic [7:0]                              release_floor_ff;
   logic [adsr_pkg::TIME_BITS-1:0]          attack_time_ff;
   logic [adsr_pkg::TIME_BITS-1:0]          decay_time_ff;
   logic [adsr_pkg::TIME_BITS-1:0]          release_time_ff;
   logic [adsr_pkg::THRESHOLD_BITS-1:0]     gate_threshold_ff;
   logic [adsr_pkg::SCALE_BITS-1:0]         tick_scale_ff;

   // Envelope state and per-tick work registers
   adsr_pkg::ctrl_state_type                state_ff, state_in;
   adsr_pkg::phase_type                     phase_ff;
   adsr_pkg::phase_type                     work_phase_ff;
   logic [adsr_pkg::LEVEL_BITS-1:0]         level_ff;
   logic                                    step_max_ff;

   // Response register
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]                              rsp_envelope_ff;
   adsr_pkg::phase_type                     rsp_stage_ff;

   // Divider hookup
   adsr_pkg::div_status_type                div_status;
   logic [adsr_pkg::SCALE_BITS-1:0]         div_quotient;
   logic                                    div_start;

   // Tick decode
   logic [adsr_pkg::SUM_BITS-1:0]           sample_sum;
   logic                                    gate_on;
   adsr_pkg::phase_type                     phase_sel;
   logic [adsr_pkg::TIME_BITS-1:0]          time_sel;
   logic                                    need_div;
   logic                                    accept;

   // Level update
   logic [adsr_pkg::LEVEL_BITS-1:0]         step;
   logic [adsr_pkg::LEVEL_BITS:0]           rise_sum;
   logic [adsr_pkg::LEVEL_BITS-1:0]         rise_level;
   logic [adsr_pkg::LEVEL_BITS-1:0]         fall_level;
   logic [adsr_pkg::LEVEL_BITS-1:0]         attack_bound;
   logic [adsr_pkg::LEVEL_BITS-1:0]         sustain_bound;
   logic [adsr_pkg::LEVEL_BITS-1:0]         floor_bound;
   logic [adsr_pkg::LEVEL_BITS-1:0]         level_new;
   adsr_pkg::phase_type                     phase_new;
   logic                                    out_free;
   logic                                    commit;

   // ---------------------------------------------------------------------------
   // Configuration port: take a write on any cycle the enable is high.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_level_ff   <= adsr_pkg::RESET_ATTACK_LEVEL;
         sustain_level_ff  <= adsr_pkg::RESET_SUSTAIN_LEVEL;
         release_floor_ff  <= adsr_pkg::RESET_RELEASE_FLOOR;
         attack_time_ff    <= adsr_pkg::RESET_STAGE_TIME;
         decay_time_ff     <= adsr_pkg::RESET_STAGE_TIME;
         release_time_ff   <= adsr_pkg::RESET_STAGE_TIME;
         gate_threshold_ff <= adsr_pkg::RESET_GATE_THRESHOLD;
         tick_scale_ff     <= adsr_pkg::RESET_TICK_SCALE;
      end else if (csr_wen) begin
         unique case (adsr_pkg::csr_index_type'(csr_index))
            adsr_pkg::CSR_ATTACK_LEVEL:   attack_level_ff   <= csr_wdata[7:0];
            adsr_pkg::CSR_SUSTAIN_LEVEL:  sustain_level_ff  <= csr_wdata[7:0];
            adsr_pkg::CSR_RELEASE_FLOOR:  release_floor_ff  <= csr_wdata[7:0];
            adsr_pkg::CSR_ATTACK_TIME:    attack_time_ff    <= csr_wdata[adsr_pkg::TIME_BITS-1:0];
            adsr_pkg::CSR_DECAY_TIME:     decay_time_ff     <= csr_wdata[adsr_pkg::TIME_BITS-1:0];
            adsr_pkg::CSR_RELEASE_TIME:   release_time_ff   <= csr_wdata[adsr_pkg::TIME_BITS-1:0];
            adsr_pkg::CSR_GATE_THRESHOLD:
               gate_threshold_ff <= csr_wdata[adsr_pkg::THRESHOLD_BITS-1:0];
            adsr_pkg::CSR_TICK_SCALE:     tick_scale_ff     <= csr_wdata[adsr_pkg::SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Gate detect and stage entry for the incoming word.
   // ---------------------------------------------------------------------------
   assign sample_sum = {1'b0, req_ch.pot_value} + {1'b0, req_ch.jack_value};
   assign gate_on    = adsr_pkg::GATE_CMP_BITS'(sample_sum) >
                       adsr_pkg::GATE_CMP_BITS'(gate_threshold_ff);

   always_comb begin
      if (!gate_on) begin
         phase_sel = adsr_pkg::PH_RELEASE;
      end else if (phase_ff == adsr_pkg::PH_RELEASE) begin
         phase_sel = adsr_pkg::PH_ATTACK;
      end else begin
         phase_sel = phase_ff;
      end
   end

   // Pick the duration of the stage this tick runs in; sustain needs no step.
   always_comb begin
      unique case (phase_sel)
         adsr_pkg::PH_ATTACK:  time_sel = attack_time_ff;
         adsr_pkg::PH_DECAY:   time_sel = decay_time_ff;
         adsr_pkg::PH_SUSTAIN: time_sel = '0;
         adsr_pkg::PH_RELEASE: time_sel = release_time_ff;
         default:              time_sel = '0;
      endcase
   end

   assign need_div  = (phase_sel != adsr_pkg::PH_SUSTAIN) && (time_sel != '0);
   assign accept    = req_ch.valid && req_ch.ready;
   assign div_start = accept && need_div;

   adsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tick_scale_ff),
      .divisor  (time_sel),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------------------
   // Level update, done once the step is known.
   // ---------------------------------------------------------------------------
   always_comb begin
      if (step_max_ff || (div_quotient > adsr_pkg::SCALE_BITS'(adsr_pkg::LEVEL_MAX))) begin
         step = adsr_pkg::LEVEL_MAX;
      end else begin
         step = div_quotient[adsr_pkg::LEVEL_BITS-1:0];
      end
   end

   assign rise_sum      = {1'b0, level_ff} + {1'b0, step};
   assign rise_level    = rise_sum[adsr_pkg::LEVEL_BITS] ? adsr_pkg::LEVEL_MAX
                                                         : rise_sum[adsr_pkg::LEVEL_BITS-1:0];
   assign fall_level    = (level_ff > step) ? (level_ff - step) : '0;
   assign attack_bound  = {attack_level_ff,  {adsr_pkg::FRACTION_BITS{1'b0}}};
   assign sustain_bound = {sustain_level_ff, {adsr_pkg::FRACTION_BITS{1'b0}}};
   assign floor_bound   = {release_floor_ff, {adsr_pkg::FRACTION_BITS{1'b0}}};

   always_comb begin
      level_new = level_ff;
      phase_new = work_phase_ff;
      unique case (work_phase_ff)
         adsr_pkg::PH_ATTACK: begin
            level_new = rise_level;
            if (rise_level > attack_bound) begin
               phase_new = adsr_pkg::PH_DECAY;
            end
         end
         adsr_pkg::PH_DECAY: begin
            level_new = fall_level;
            if (fall_level < sustain_bound) begin
               phase_new = adsr_pkg::PH_SUSTAIN;
            end
         end
         adsr_pkg::PH_SUSTAIN: begin
            level_new = sustain_bound;
         end
         adsr_pkg::PH_RELEASE: begin
            // Clamp up to the floor after the fall.
            level_new = (fall_level < floor_bound) ? floor_bound : fall_level;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Control: next state and outputs.
   // ---------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adsr_pkg::CS_IDLE: begin
            if (req_ch.valid) begin
               state_in = need_div ? adsr_pkg::CS_DIVIDE : adsr_pkg::CS_APPLY;
            end
         end
         adsr_pkg::CS_DIVIDE: begin
            if (div_status.done) begin
               state_in = adsr_pkg::CS_APPLY;
            end
         end
         adsr_pkg::CS_APPLY: begin
            if (out_free) begin
               state_in = adsr_pkg::CS_IDLE;
            end
         end
         default: state_in = adsr_pkg::CS_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == adsr_pkg::CS_IDLE);
      commit       = (state_ff == adsr_pkg::CS_APPLY) && out_free;
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adsr_pkg::CS_IDLE;
         phase_ff     <= adsr_pkg::PH_RELEASE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            phase_ff <= phase_new;
            level_ff <= level_new;
         end
      end
      // Hold the tick's stage and step choice for the update.
      if (accept) begin
         work_phase_ff <= phase_sel;
         step_max_ff   <= (time_sel == '0);
      end
      if (commit) begin
         rsp_envelope_ff <= level_new[adsr_pkg::LEVEL_BITS-1:adsr_pkg::FRACTION_BITS];
         rsp_stage_ff    <= phase_new;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.envelope = rsp_envelope_ff;
   assign rsp_ch.stage    = rsp_stage_ff;

   `ADSR_ASSERT_SAME(a_apply_div_idle, clock, reset, state_ff == adsr_pkg::CS_APPLY,
      !div_status.busy)
   `ADSR_ASSERT_SAME(a_attack_under_peak, clock, reset,
      rsp_valid_ff && rsp_stage_ff == adsr_pkg::PH_ATTACK, rsp_envelope_ff <= attack_level_ff)
   `ADSR_ASSERT_SAME(a_release_above_floor, clock, reset,
      rsp_valid_ff && rsp_stage_ff == adsr_pkg::PH_RELEASE, rsp_envelope_ff >= release_floor_ff)

endmodule

[test/envelope_checker.sv]
// Envelope checker: tracks configuration, predicts each response word and compares it.
`timescale 1ns / 1ps
module envelope_checker (
   input  logic                                clock,
   input  logic                                reset,
   adsr_req_if                                 req_mon,
   adsr_rsp_if                                 rsp_mon,
   input  logic                                csr_wen,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  pending_words,
   output int                                  checked_words,
   output logic [3:0]                          stages_seen
);
   import adsr_pkg::*;

   typedef struct packed {
      logic [7:0] envelope;
      phase_type  stage;
   } envelope_word_type;

   envelope_word_type predicted_levels[$];

   // shadow copy of the block's registers and envelope state
   logic [7:0]            attack_level_r;
   logic [7:0]            sustain_level_r;
   logic [7:0]            release_floor_r;
   logic [7:0]            attack_time_r;
   logic [7:0]            decay_time_r;
   logic [7:0]            release_time_r;
   logic [12:0]           gate_threshold_r;
   logic [31:0]           tick_scale_r;
   phase_type             env_phase;
   logic [LEVEL_BITS-1:0] env_level;

   function automatic logic [LEVEL_BITS-1:0] stage_step(logic [TIME_BITS-1:0] stage_time);
      logic [SCALE_BITS-1:0] quotient;
      if (stage_time == '0)
         return LEVEL_MAX;
      quotient = tick_scale_r / SCALE_BITS'(stage_time);
      if (quotient > SCALE_BITS'(LEVEL_MAX))
         return LEVEL_MAX;
      return quotient[LEVEL_BITS-1:0];
   endfunction

   function automatic logic [LEVEL_BITS-1:0] level_fall(logic [LEVEL_BITS-1:0] value,
                                                        logic [LEVEL_BITS-1:0] amount);
      return (value > amount) ? value - amount : '0;
   endfunction

   // Advance the envelope by one tick and return the word the block must send.
   function automatic envelope_word_type advance_envelope(logic [SAMPLE_BITS-1:0] pot,
                                                          logic [SAMPLE_BITS-1:0] jack);
      logic [SUM_BITS-1:0]   gate_sum;
      logic [LEVEL_BITS:0]   raised;
      logic [LEVEL_BITS-1:0] floor_level;
      envelope_word_type     word;
      gate_sum = SUM_BITS'(pot) + SUM_BITS'(jack);
      if (GATE_CMP_BITS'(gate_sum) > GATE_CMP_BITS'(gate_threshold_r)) begin
         if (env_phase == PH_RELEASE)
            env_phase = PH_ATTACK;
      end else begin
         env_phase = PH_RELEASE;
      end
      case (env_phase)
         PH_ATTACK: begin
            raised = {1'b0, env_level} + {1'b0, stage_step(attack_time_r)};
            env_level = raised[LEVEL_BITS] ? LEVEL_MAX : raised[LEVEL_BITS-1:0];
            if (env_level > {attack_level_r, {FRACTION_BITS{1'b0}}})
               env_phase = PH_DECAY;
         end
         PH_DECAY: begin
            env_level = level_fall(env_level, stage_step(decay_time_r));
            if (env_level < {sustain_level_r, {FRACTION_BITS{1'b0}}})
               env_phase = PH_SUSTAIN;
         end
         PH_SUSTAIN: begin
            env_level = {sustain_level_r, {FRACTION_BITS{1'b0}}};
         end
         default: begin
            env_level = level_fall(env_level, stage_step(release_time_r));
            floor_level = {release_floor_r, {FRACTION_BITS{1'b0}}};
            if (env_level < floor_level)
               env_level = floor_level;
         end
      endcase
      word.envelope = env_level[LEVEL_BITS-1:FRACTION_BITS];
      word.stage = env_phase;
      return word;
   endfunction

   always @(posedge clock) begin
      envelope_word_type want;
      if (reset) begin
         attack_level_r   = RESET_ATTACK_LEVEL;
         sustain_level_r  = RESET_SUSTAIN_LEVEL;
         release_floor_r  = RESET_RELEASE_FLOOR;
         attack_time_r    = RESET_STAGE_TIME;
         decay_time_r     = RESET_STAGE_TIME;
         release_time_r   = RESET_STAGE_TIME;
         gate_threshold_r = RESET_GATE_THRESHOLD;
         tick_scale_r     = RESET_TICK_SCALE;
         env_phase        = PH_RELEASE;
         env_level        = '0;
         predicted_levels.delete();
         fail_count       = 0;
         checked_words    = 0;
         stages_seen      = '0;
      end else begin
         // compare first: a word accepted now cannot answer a request taken at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            stages_seen[rsp_mon.stage] = 1'b1;
            if (predicted_levels.size() == 0) begin
               $error("response word with no request pending: envelope %0d stage %0d",
                      rsp_mon.envelope, rsp_mon.stage);
               fail_count++;
            end else begin
               want = predicted_levels.pop_front();
               checked_words++;
               if (rsp_mon.envelope !== want.envelope) begin
                  $error("envelope mismatch: expected %0d, got %0d",
                         want.envelope, rsp_mon.envelope);
                  fail_count++;
               end
               if (rsp_mon.stage !== want.stage) begin
                  $error("stage mismatch: expected %0d, got %0d", want.stage, rsp_mon.stage);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_levels.push_back(advance_envelope(req_mon.pot_value, req_mon.jack_value));
         if (csr_wen) begin
            case (csr_index_type'(csr_index))
               CSR_ATTACK_LEVEL:   attack_level_r   = csr_wdata[7:0];
               CSR_SUSTAIN_LEVEL:  sustain_level_r  = csr_wdata[7:0];
               CSR_RELEASE_FLOOR:  release_floor_r  = csr_wdata[7:0];
               CSR_ATTACK_TIME:    attack_time_r    = csr_wdata[7:0];
               CSR_DECAY_TIME:     decay_time_r     = csr_wdata[7:0];
               CSR_RELEASE_TIME:   release_time_r   = csr_wdata[7:0];
               CSR_GATE_THRESHOLD: gate_threshold_r = csr_wdata[12:0];
               CSR_TICK_SCALE:     tick_scale_r     = csr_wdata[31:0];
               default: ;
            endcase
         end
      end
      pending_words = predicted_levels.size();
   end

endmodule

[test/testbench.sv]
// Top of the envelope generator testbench: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module testbench;
   import adsr_pkg::*;

   // longest stretch without any accepted word before the run is declared hung;
   // covers the long receiver hold-off, a full divide and the widest sender gap
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SUM_MAX        = 2 * ((1 << SAMPLE_BITS) - 1);
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES  = 9;

   typedef struct {
      logic [7:0]  attack_level;
      logic [7:0]  sustain_level;
      logic [7:0]  release_floor;
      logic [7:0]  attack_time;
      logic [7:0]  decay_time;
      logic [7:0]  release_time;
      logic [12:0] gate_threshold;
      logic [31:0] tick_scale;
   } envelope_setup_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int   fail_count;
   int   pending_words;
   int   checked_words;
   logic [3:0] stages_seen;

   int   words_sent;
   int   burst_left;
   int   setups_loaded;
   int   idle_cycles;
   logic hold_off_request;
   logic hold_off_done;

   envelope_setup_type setup;

   adsr_req_if req_ch ();
   adsr_rsp_if rsp_ch ();

   adsr_envelope_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   envelope_checker envelope_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .checked_words (checked_words),
      .stages_seen   (stages_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: stall on its own segment pattern, and hold off once for a long
   // stretch while the sender keeps offering words, so the block backs up.
   initial begin
      int seg_len;
      rsp_ch.ready = 1'b0;
      hold_off_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end
         seg_len = $urandom_range(200, 20);
         case ($urandom_range(3, 0))
            0: begin
               // always ready
               rsp_ch.ready = 1'b1;
               repeat (seg_len) @(negedge clock);
            end
            1: begin
               // coin flip every cycle
               repeat (seg_len) begin
                  rsp_ch.ready = 1'($urandom_range(1, 0));
                  @(negedge clock);
               end
            end
            2: begin
               // long stalls with short windows of readiness
               rsp_ch.ready = 1'b0;
               repeat ($urandom_range(60, 1)) @(negedge clock);
               rsp_ch.ready = 1'b1;
               repeat ($urandom_range(5, 1)) @(negedge clock);
            end
            default: begin
               // mostly ready, dropping ready one time in eight
               repeat (seg_len) begin
                  rsp_ch.ready = ($urandom_range(7, 0) != 0);
                  @(negedge clock);
               end
            end
         endcase
      end
   end

   // Write one register; called at a falling edge, returns at the next one.
   task automatic write_reg(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] value);
      csr_wen   = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
   endtask

   // Load a whole setup; the block must be idle.
   task automatic load_setup(input envelope_setup_type s);
      setup = s;
      write_reg(CSR_ATTACK_LEVEL,   CSR_DATA_BITS'(s.attack_level));
      write_reg(CSR_SUSTAIN_LEVEL,  CSR_DATA_BITS'(s.sustain_level));
      write_reg(CSR_RELEASE_FLOOR,  CSR_DATA_BITS'(s.release_floor));
      write_reg(CSR_ATTACK_TIME,    CSR_DATA_BITS'(s.attack_time));
      write_reg(CSR_DECAY_TIME,     CSR_DATA_BITS'(s.decay_time));
      write_reg(CSR_RELEASE_TIME,   CSR_DATA_BITS'(s.release_time));
      write_reg(CSR_GATE_THRESHOLD, CSR_DATA_BITS'(s.gate_threshold));
      write_reg(CSR_TICK_SCALE,     s.tick_scale);
      csr_wen = 1'b0;
      setups_loaded++;
   endtask

   // Drop valid, wait until every predicted word has come back, then idle a bit.
   task automatic drain(input int tail_cycles);
      req_ch.valid = 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (tail_cycles) @(negedge clock);
   endtask

   // Offer one word and hold it until accepted; bursts of random length with
   // random gaps, a third of the gaps empty so back-to-back stretches occur.
   task automatic send_word(input logic [SAMPLE_BITS-1:0] pot,
                            input logic [SAMPLE_BITS-1:0] jack);
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         if ($urandom_range(2, 0) != 0)
            repeat ($urandom_range(25, 1)) @(negedge clock);
         burst_left = $urandom_range(30, 1);
      end
      req_ch.valid      = 1'b1;
      req_ch.pot_value  = pot;
      req_ch.jack_value = jack;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      words_sent++;
   endtask

   // Split a sample sum that gives the wanted gate into pot and jack parts.
   // One time in eight, land right at the threshold edge.
   task automatic make_gate_word(input logic gate_on,
                                 output logic [SAMPLE_BITS-1:0] pot,
                                 output logic [SAMPLE_BITS-1:0] jack);
      int thr;
      int total;
      int lo;
      int hi;
      thr = int'(setup.gate_threshold);
      if (gate_on && thr < SUM_MAX)
         total = ($urandom_range(7, 0) == 0) ? thr + 1 : $urandom_range(SUM_MAX, thr + 1);
      else if (gate_on)
         total = SUM_MAX;
      else begin
         if (thr > SUM_MAX)
            thr = SUM_MAX;
         total = ($urandom_range(7, 0) == 0) ? thr : $urandom_range(thr, 0);
      end
      lo   = (total > 4095) ? total - 4095 : 0;
      hi   = (total < 4095) ? total : 4095;
      pot  = SAMPLE_BITS'($urandom_range(hi, lo));
      jack = SAMPLE_BITS'(total - int'(pot));
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(7, 0))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   function automatic logic [7:0] pick_time();
      case ($urandom_range(7, 0))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255, 1));
      endcase
   endfunction

   // Random setup whose step is a few levels per tick, so gate runs of a few
   // dozen words walk through attack, decay and sustain; extremes now and then.
   function automatic envelope_setup_type random_setup();
      envelope_setup_type s;
      logic [31:0]        typical;
      s.attack_level  = pick_level();
      s.sustain_level = pick_level();
      s.release_floor = ($urandom_range(3, 0) == 0) ? pick_level() : 8'd0;
      s.attack_time   = pick_time();
      s.decay_time    = pick_time();
      s.release_time  = pick_time();
      case ($urandom_range(7, 0))
         0:       s.gate_threshold = 13'd0;
         1:       s.gate_threshold = 13'(SUM_MAX);
         default: s.gate_threshold = 13'($urandom_range(6000, 500));
      endcase
      typical = (32'(s.attack_time) + 32'(s.decay_time) + 32'(s.release_time)) / 3 + 1;
      case ($urandom_range(9, 0))
         0:       s.tick_scale = 32'hFFFF_FFFF;
         1:       s.tick_scale = 32'd0;
         2:       s.tick_scale = $urandom;
         default: s.tick_scale = 32'($urandom_range(12, 1)) * 32'd65536 * typical
                                 + 32'($urandom_range(65535, 0));
      endcase
      return s;
   endfunction

   // Mostly well-formed gate sequences (a run of gate-on ticks, then gate-off),
   // with one pick in ten a single word of raw noise; cut the last runs short at the word budget.
   task automatic run_phase(input int words);
      int sent;
      int run_len;
      logic [SAMPLE_BITS-1:0] pot;
      logic [SAMPLE_BITS-1:0] jack;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(9, 0) == 0) begin
            send_word(SAMPLE_BITS'($urandom_range(4095, 0)),
                      SAMPLE_BITS'($urandom_range(4095, 0)));
            sent++;
         end else begin
            run_len = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 80)
                                                  : $urandom_range(60, 1);
            if (run_len > words - sent)
               run_len = words - sent;
            repeat (run_len) begin
               make_gate_word(1'b1, pot, jack);
               send_word(pot, jack);
            end
            sent += run_len;
            run_len = $urandom_range(15, 1);
            if (run_len > words - sent)
               run_len = words - sent;
            repeat (run_len) begin
               make_gate_word(1'b0, pot, jack);
               send_word(pot, jack);
            end
            sent += run_len;
         end
      end
      drain(4);
   endtask

   initial begin
      envelope_setup_type s;
      reset             = 1'b1;
      csr_wen           = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.pot_value  = '0;
      req_ch.jack_value = '0;
      hold_off_request  = 1'b0;
      words_sent        = 0;
      burst_left        = 0;
      setups_loaded     = 0;
      setup = '{attack_level: RESET_ATTACK_LEVEL, sustain_level: RESET_SUSTAIN_LEVEL,
                release_floor: RESET_RELEASE_FLOOR, attack_time: RESET_STAGE_TIME,
                decay_time: RESET_STAGE_TIME, release_time: RESET_STAGE_TIME,
                gate_threshold: RESET_GATE_THRESHOLD, tick_scale: RESET_TICK_SCALE};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset values, sample extremes, sum right at and just over the threshold.
      send_word(12'd0, 12'd0);
      send_word(12'd4095, 12'd4095);
      send_word(12'd682, 12'd683);
      send_word(12'd683, 12'd683);
      send_word(12'd4095, 12'd0);
      send_word(12'd0, 12'd4095);
      drain(4);

      // Zero stage times: attack overflows and saturates, decay underflows to zero
      // and stays in decay with a zero sustain level, release is raised to the floor.
      load_setup('{attack_level: 8'd255, sustain_level: 8'd0, release_floor: 8'd200,
                   attack_time: 8'd0, decay_time: 8'd0, release_time: 8'd0,
                   gate_threshold: 13'd0, tick_scale: RESET_TICK_SCALE});
      send_word(12'd1, 12'd0);
      send_word(12'd0, 12'd1);
      send_word(12'd2048, 12'd2048);
      send_word(12'd0, 12'd0);
      send_word(12'd0, 12'd0);
      drain(4);

      // Largest tick scale: every step saturates, so decay lands in sustain at once.
      load_setup('{attack_level: 8'd100, sustain_level: 8'd50, release_floor: 8'd0,
                   attack_time: 8'd1, decay_time: 8'd2, release_time: 8'd255,
                   gate_threshold: 13'd4095, tick_scale: 32'hFFFF_FFFF});
      send_word(12'd4095, 12'd1);
      send_word(12'd2048, 12'd2048);
      send_word(12'd4095, 12'd4095);
      send_word(12'd4095, 12'd0);
      drain(4);

      // Zero tick scale: steps of zero; no sum exceeds the threshold, so both words release and the level holds.
      load_setup('{attack_level: 8'd0, sustain_level: 8'd255, release_floor: 8'd0,
                   attack_time: 8'd64, decay_time: 8'd64, release_time: 8'd64,
                   gate_threshold: 13'd8190, tick_scale: 32'd0});
      send_word(12'd4095, 12'd4095);
      send_word(12'd0, 12'd0);
      drain(4);

      // Extreme setups: everything at its low end, then everything at its high end.
      load_setup('{attack_level: 8'd0, sustain_level: 8'd0, release_floor: 8'd0,
                   attack_time: 8'd0, decay_time: 8'd0, release_time: 8'd0,
                   gate_threshold: 13'd0, tick_scale: 32'd0});
      run_phase(40);
      load_setup('{attack_level: 8'd255, sustain_level: 8'd255, release_floor: 8'd255,
                   attack_time: 8'd255, decay_time: 8'd255, release_time: 8'd255,
                   gate_threshold: 13'(SUM_MAX), tick_scale: 32'hFFFF_FFFF});
      run_phase(40);

      // Random setups; raise the long receiver hold-off in the third one.
      for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         s = random_setup();
         load_setup(s);
         if (phase_idx == 2)
            hold_off_request = 1'b1;
         run_phase(110);
      end

      drain(40);
      $display("Covered %0d setups, %0d request words sent, %0d response words checked.",
               setups_loaded, words_sent, checked_words);
      $display("Stages seen (bit per stage, release..attack): %b, long hold-off done: %0d",
               stages_seen, hold_off_done);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
